### sv/gn2d_pkg.sv
// Package for gradient_noise_2d: shared widths, request codes and helpers.
// No dependencies.
package gn2d_pkg;

  localparam int unsigned MAX_GRID_DEF = 63;
  localparam int unsigned GRID_W       = 6;
  localparam int unsigned GRAD_W       = 16;
  localparam int unsigned POINT_W      = 18;
  localparam int unsigned NOISE_W      = 16;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 1'b1;

  localparam logic [GRID_W-1:0] GRID_RESET = 6'd8;

  // floor(v/2^16 + 1/2) for a signed value; arithmetic shift is floor
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd32768;
    return t >>> 16;
  endfunction

endpackage

### sv/gn2d_if.sv
// Valid/ready channel interfaces for gradient_noise_2d.
// Depends on gn2d_pkg.
interface gn2d_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    req_type;
  logic [gn2d_pkg::IDX_W-1:0]              grad_row;
  logic [gn2d_pkg::IDX_W-1:0]              grad_col;
  logic signed [gn2d_pkg::GRAD_W-1:0]      grad_x;
  logic signed [gn2d_pkg::GRAD_W-1:0]      grad_y;
  logic signed [gn2d_pkg::POINT_W-1:0]     point_x;
  logic signed [gn2d_pkg::POINT_W-1:0]     point_y;
  modport source (output valid, req_type, grad_row, grad_col, grad_x, grad_y,
                  point_x, point_y, input ready);
  modport sink   (input valid, req_type, grad_row, grad_col, grad_x, grad_y,
                  point_x, point_y, output ready);
endinterface

interface gn2d_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [gn2d_pkg::NOISE_W-1:0] noise;
  logic                                outside;
  modport source (output valid, noise, outside, input ready);
  modport sink   (input valid, noise, outside, output ready);
endinterface

interface gn2d_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [gn2d_pkg::CFG_IDX_W-1:0]     index;
  logic [gn2d_pkg::GRID_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/gradient_noise_2d.sv
// Top level of gradient_noise_2d: 2D gradient noise pipeline and gradient memory.
// Depends on gn2d_pkg, gn2d_if and gn2d_fade.
//
//  channel | dir | transaction
//  in_     | in  | load gradient (req_type 0) or noise query (req_type 1)
//  out_    | out | noise value and outside flag, one per query
//  cfg_    | in  | cells across x (index 0), cells across y (index 1)
//
// One item per cycle while not stalled; a query passes s1-s4 and the output register to out_valid.
// Four memory banks (by row/col parity) give the four corners in one read.
// Whole pipeline advances only when its last stage can move (out_ready or
// empty output register). Synchronous active-low reset clears valids and
// sets grid size to 8; the gradient memory is not cleared. in_ and cfg_ are
// not ready during reset.
module gradient_noise_2d #(
  parameter int unsigned MAX_GRID = gn2d_pkg::MAX_GRID_DEF
) (
  input logic clk,
  input logic rst_n,
  gn2d_in_if.sink    in_ch,
  gn2d_out_if.source out_ch,
  gn2d_cfg_if.sink   cfg_ch
);
  localparam int unsigned SIDE  = MAX_GRID + 1;
  localparam int unsigned CW    = $clog2(SIDE) < 1 ? 1 : $clog2(SIDE);
  localparam int unsigned HW    = (CW > 1) ? CW - 1 : 1;
  localparam int unsigned BA_W  = 2 * HW;
  localparam int unsigned BANK_D = 1 << BA_W;

  logic [gn2d_pkg::GRID_W-1:0] gw_r, gh_r;
  logic adv;

  assign cfg_ch.ready = rst_n;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= gn2d_pkg::GRID_RESET;
      gh_r <= gn2d_pkg::GRID_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        gn2d_pkg::REG_CELLS_X: gw_r <= cfg_ch.data;
        gn2d_pkg::REG_CELLS_Y: gh_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // stage 0: accept, scale
  logic in_fire;
  assign in_ch.ready = adv && rst_n;
  assign in_fire = in_ch.valid && in_ch.ready;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, o_v_r;
  logic s1_out_r, s2_out_r, s3_out_r, s4_out_r;
  logic signed [24:0] sx, sy;
  logic [16:0] x0w, y0w;
  logic outside0;

  assign sx = 25'(in_ch.point_x) * $signed({19'd0, gw_r});
  assign sy = 25'(in_ch.point_y) * $signed({19'd0, gh_r});
  assign x0w = 17'(sx >>> 16);
  assign y0w = 17'(sy >>> 16);
  assign outside0 = sx[24] || sy[24] || (32'(x0w) + 1 > 32'(gw_r)) ||
                    (32'(y0w) + 1 > 32'(gh_r)) ||
                    (32'(x0w) + 1 > MAX_GRID) || (32'(y0w) + 1 > MAX_GRID);

  // bank address for a corner: bank by parity, entry by halved coordinates
  function automatic logic [BA_W-1:0] baddr(input logic [CW:0] r, input logic [CW:0] c);
    logic [CW:0] rh, ch;
    rh = r >> 1;
    ch = c >> 1;
    return {rh[HW-1:0], ch[HW-1:0]};
  endfunction

  logic [CW:0] x0c, y0c, x1c, y1c;
  assign x0c = (CW+1)'(x0w);
  assign y0c = (CW+1)'(y0w);
  assign x1c = x0c + 1'b1;
  assign y1c = y0c + 1'b1;

  // four banks, index [row parity][col parity]
  logic [31:0] mem00 [BANK_D], mem01 [BANK_D], mem10 [BANK_D], mem11 [BANK_D];
  logic [31:0] rd_r [4];
  logic [BA_W-1:0] ra [4];
  logic [CW:0] lr, lc;
  logic load_ok;
  logic [BA_W-1:0] wa;
  logic [31:0] wd;

  assign lr = (CW+1)'(in_ch.grad_row);
  assign lc = (CW+1)'(in_ch.grad_col);
  assign load_ok = in_fire && (in_ch.req_type == gn2d_pkg::REQ_LOAD) &&
                   (32'(in_ch.grad_row) <= MAX_GRID) && (32'(in_ch.grad_col) <= MAX_GRID);
  assign wa = baddr(lr, lc);
  assign wd = {in_ch.grad_y, in_ch.grad_x};

  // ra[k]: k = {row parity, col parity} of the bank; even or odd corner of the cell
  logic [CW:0] row_ev, row_od, col_ev, col_od;
  assign row_ev = y0c[0] ? y1c : y0c;
  assign row_od = y0c[0] ? y0c : y1c;
  assign col_ev = x0c[0] ? x1c : x0c;
  assign col_od = x0c[0] ? x0c : x1c;
  assign ra[0] = baddr(row_ev, col_ev);
  assign ra[1] = baddr(row_ev, col_od);
  assign ra[2] = baddr(row_od, col_ev);
  assign ra[3] = baddr(row_od, col_od);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      case ({lr[0], lc[0]})
        2'b00:   mem00[wa] <= wd;
        2'b01:   mem01[wa] <= wd;
        2'b10:   mem10[wa] <= wd;
        default: mem11[wa] <= wd;
      endcase
    end
    if (adv) begin
      rd_r[0] <= mem00[ra[0]];
      rd_r[1] <= mem01[ra[1]];
      rd_r[2] <= mem10[ra[2]];
      rd_r[3] <= mem11[ra[3]];
    end
  end

  // stage 1 payload
  logic [15:0] fx1_r, fy1_r;
  logic xp1_r, yp1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      fx1_r <= sx[15:0];
      fy1_r <= sy[15:0];
      xp1_r <= x0c[0];
      yp1_r <= y0c[0];
    end
  end

  // fade units: result valid for stage 3
  logic [16:0] wx, wy;
  gn2d_fade u_fx (.clk(clk), .en(adv), .f(sx[15:0]), .w(wx));
  gn2d_fade u_fy (.clk(clk), .en(adv), .f(sy[15:0]), .w(wy));

  // stage 1 -> 2: dot products; reads a forwarded load in the same cycle
  // cannot happen: a load ahead of a query is written at its accept edge and the
  // query reads the memory at its own, later accept edge.
  logic [31:0] g00, g01, g10, g11;
  assign g00 = rd_r[{yp1_r, xp1_r}];
  assign g01 = rd_r[{yp1_r, ~xp1_r}];
  assign g10 = rd_r[{~yp1_r, xp1_r}];
  assign g11 = rd_r[{~yp1_r, ~xp1_r}];

  function automatic logic signed [34:0] dot(input logic [31:0] g,
      input logic signed [17:0] dx, input logic signed [17:0] dy);
    logic signed [15:0] gx, gy;
    gx = g[15:0];
    gy = g[31:16];
    return 35'(dx * gx) + 35'(dy * gy);
  endfunction

  logic signed [17:0] dx0, dx1, dy0, dy1;
  assign dx0 = $signed({2'b00, fx1_r});
  assign dx1 = dx0 - 18'sd65536;
  assign dy0 = $signed({2'b00, fy1_r});
  assign dy1 = dy0 - 18'sd65536;

  logic signed [34:0] n00_r, n01_r, n10_r, n11_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      n00_r <= dot(g00, dx0, dy0);
      n01_r <= dot(g01, dx1, dy0);
      n10_r <= dot(g10, dx0, dy1);
      n11_r <= dot(g11, dx1, dy1);
    end
  end

  // stage 2 -> 3 wait for fade; register dots again aligned with wx
  logic signed [34:0] a00_r, a01_r, a10_r, a11_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a00_r <= n00_r; a01_r <= n01_r; a10_r <= n10_r; a11_r <= n11_r;
    end
  end

  // stage 3: x blend (a*(65536-w) + b*w = a*65536 + (b-a)*w)
  logic signed [35:0] d0, d1;
  logic signed [63:0] ix0, ix1;
  logic [16:0] wy4_r;
  logic signed [34:0] ix0_r, ix1_r;
  assign d0 = 36'(a01_r) - 36'(a00_r);
  assign d1 = 36'(a11_r) - 36'(a10_r);
  assign ix0 = gn2d_pkg::rnd16((64'(a00_r) <<< 16) + 64'(d0) * $signed({47'd0, wx}));
  assign ix1 = gn2d_pkg::rnd16((64'(a10_r) <<< 16) + 64'(d1) * $signed({47'd0, wx}));
  always_ff @(posedge clk) begin
    if (adv) begin
      ix0_r <= 35'(ix0);
      ix1_r <= 35'(ix1);
      wy4_r <= wy;
    end
  end

  // stage 4: y blend, round, saturate into output register
  logic signed [35:0] dv;
  logic signed [63:0] v, r;
  logic signed [15:0] sat;
  assign dv = 36'(ix1_r) - 36'(ix0_r);
  assign v  = gn2d_pkg::rnd16((64'(ix0_r) <<< 16) + 64'(dv) * $signed({47'd0, wy4_r}));
  assign r  = gn2d_pkg::rnd16(v);
  assign sat = (r > 64'sd32767) ? 16'sd32767 : (r < -64'sd32768) ? -16'sd32768 : 16'(r);

  assign adv = !o_v_r || out_ch.ready;

  logic signed [15:0] noise_r;
  logic out_flag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0; o_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_fire && (in_ch.req_type == gn2d_pkg::REQ_QUERY);
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      o_v_r  <= s4_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_out_r   <= outside0;
      s2_out_r   <= s1_out_r;
      s3_out_r   <= s2_out_r;
      s4_out_r   <= s3_out_r;
      out_flag_r <= s4_out_r;
      noise_r    <= s4_out_r ? 16'sd0 : sat;
    end
  end

  assign out_ch.valid   = o_v_r;
  assign out_ch.noise   = noise_r;
  assign out_ch.outside = out_flag_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && !out_ch.ready |=> o_v_r && $stable(noise_r)) else $error("out held");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && out_flag_r |-> noise_r == 16'sd0) else $error("outside nonzero");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> !in_ch.ready) else $error("accept in stall");
endmodule

### sv/gn2d_fade.sv
// Fade curve 6t^5-15t^4+10t^3, Q0.16 in and Q1.16 out, three registered stages.
// No dependencies.
module gn2d_fade (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] f,
  output logic [16:0] w
);
  logic [15:0] f_r, f2_r, f3_r;
  logic [31:0] f_sq;
  logic [35:0] p_nxt;
  logic [19:0] p16_r, p16b_r;
  logic [35:0] prod;
  logic [32:0] r;
  logic [16:0] w_r;

  assign f_sq = 32'(f) * 32'(f);
  // p = 6f^2 - 15*2^16 f + 10*2^32, always positive and below 2^36
  assign p_nxt = 36'(6) * 36'(f_sq) + 36'd42949672960
                 - 36'(15) * {4'd0, f, 16'd0};

  assign prod = 36'(f3_r) * 36'(p16b_r);
  assign r    = 33'((prod + 36'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: square, polynomial tail
      f_r    <= f;
      f2_r   <= f_sq[31:16];
      p16_r  <= 20'((p_nxt + 36'd32768) >> 16);
      // stage 2: cube
      f3_r   <= 16'((32'(f2_r) * 32'(f_r)) >> 16);
      p16b_r <= p16_r;
      // stage 3: final product, clamp to 1.0
      w_r    <= (r > 33'd65536) ? 17'd65536 : r[16:0];
    end
  end

  assign w = w_r;
endmodule
